// ===== hw/rtl/tkd_pkg.sv =====
// ============================================================================
// tkd_pkg: shared types and constants of the tent kernel density grid
// Grid geometry, field widths, codes, state encoding and the tent tap weight.
// ============================================================================
package tkd_pkg;

    // grid geometry
    localparam int GRID_CELLS    = 1024;
    localparam int KERNEL_RADIUS = 10;
    localparam int CELL_W        = $clog2(GRID_CELLS);
    localparam int ADDR_W        = 2 * CELL_W;
    localparam int DENS_W        = 32;

    // window walk widths
    localparam int CNT_W = $clog2(2 * KERNEL_RADIUS + 1);
    localparam int TAP_W = $clog2(KERNEL_RADIUS + 1);
    localparam int WGT_W = 2 * TAP_W;

    // field widths
    localparam int KIND_W    = 2;
    localparam int POS_W     = 21;
    localparam int OFS_W     = 21;
    localparam int SCL_W     = 20;
    localparam int MARGIN_W  = 8;
    localparam int DSQ_W     = 63;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 63;

    // position to grid mapping widths
    localparam int SUM_W     = OFS_W + 2;
    localparam int PROD_W    = SUM_W + SCL_W + 1;
    localparam int MAP_SHIFT = 24;
    localparam int GPOS_W    = PROD_W - MAP_SHIFT;

    // register reset values
    localparam logic [OFS_W-1:0]    VIEW_OFFSET_RST = OFS_W'(512128);
    localparam logic [SCL_W-1:0]    VIEW_SCALE_RST  = SCL_W'(16384);
    localparam logic [MARGIN_W-1:0] EDGE_MARGIN_RST = MARGIN_W'(10);
    localparam logic [DSQ_W-1:0]    FAR_DENSITY_RST = DSQ_W'(100000000);

    // item kinds
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUB   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MARGIN   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OFF_GRID = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_SCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MARGIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_DENSITY = 2'd3;

    // control sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP_MUL,
        ST_MAP_TRUNC,
        ST_CHECK,
        ST_QUERY_MAG,
        ST_QUERY_SQ,
        ST_WALK,
        ST_DONE
    } tkd_state_t;

    // window walk command
    typedef struct packed {
        logic              start;
        logic              sub;
        logic [CELL_W-1:0] base_x;
        logic [CELL_W-1:0] base_y;
    } tkd_walk_cmd_t;

    // memory access request
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DENS_W-1:0] wr_data;
    } tkd_ram_req_t;

    // one axis of the tent kernel: R - |cnt - R|
    function automatic logic [TAP_W-1:0] tap_weight(input logic [CNT_W-1:0] cnt);
        logic [TAP_W-1:0] w;
        if (int'(cnt) <= KERNEL_RADIUS)
            w = TAP_W'(cnt);
        else
            w = TAP_W'(2 * KERNEL_RADIUS - int'(cnt));
        return w;
    endfunction

endpackage

// ===== hw/rtl/tkd_if.sv =====
// ============================================================================
// tkd_if: item and result channels of the tent kernel density grid
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ============================================================================
interface tkd_item_if import tkd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;

    modport source (output valid, kind, x_pos, y_pos, input ready);
    modport sink   (input valid, kind, x_pos, y_pos, output ready);
endinterface

interface tkd_result_if import tkd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DSQ_W-1:0]    density_sq;

    modport source (output valid, status, density_sq, input ready);
    modport sink   (input valid, status, density_sq, output ready);
endinterface

// ===== hw/rtl/tkd_ram.sv =====
// ============================================================================
// tkd_ram: simple dual port synchronous memory
// One write and one read port, read data registered.
// ============================================================================
module tkd_ram #(
    parameter int ADDR_W = 20,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/tkd_map.sv =====
// ============================================================================
// tkd_map: position to grid coordinate mapping for one axis
// g = trunc((pos + offset) * scale / 2^24), two register stages.
// ============================================================================
module tkd_map import tkd_pkg::*; (
    input  logic                     clk,
    input  logic signed [POS_W-1:0]  pos,
    input  logic [OFS_W-1:0]         offset,
    input  logic [SCL_W-1:0]         scale,
    output logic signed [GPOS_W-1:0] gpos
);

    logic signed [SUM_W-1:0]  sum;
    logic signed [SCL_W:0]    scale_s;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] rnd;
    logic signed [GPOS_W-1:0] g_next;
    logic signed [GPOS_W-1:0] g_reg;

    // offset and scale
    assign sum       = {{(SUM_W-POS_W){pos[POS_W-1]}}, pos} + {{(SUM_W-OFS_W){1'b0}}, offset};
    assign scale_s   = {1'b0, scale};
    assign prod_next = sum * scale_s;

    // shift with truncation toward zero
    assign rnd    = prod_reg + (prod_reg[PROD_W-1] ? PROD_W'((64'd1 << MAP_SHIFT) - 64'd1)
                                                  : PROD_W'(0));
    assign g_next = rnd[PROD_W-1:MAP_SHIFT];

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        g_reg    <= g_next;
    end

    assign gpos = g_reg;

endmodule

// ===== hw/rtl/tkd_walk.sv =====
// ============================================================================
// tkd_walk: window read-modify-write walker
// Steps over the kernel window one cell a cycle: read, then add or subtract
// the tent weight and write back in the next cycle.
// ============================================================================
module tkd_walk import tkd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  tkd_walk_cmd_t     cmd,
    input  logic [DENS_W-1:0] rd_data,
    output tkd_ram_req_t      req,
    output logic              done
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(2 * KERNEL_RADIUS);

    logic              active_reg, active_next;
    logic [CNT_W-1:0]  ci_reg, ci_next;
    logic [CNT_W-1:0]  cj_reg, cj_next;
    logic              s1_valid_reg;
    logic              s1_last_reg;
    logic              sub_reg;
    logic [CELL_W-1:0] bx_reg;
    logic [CELL_W-1:0] by_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [WGT_W-1:0]  s1_wgt_reg;
    logic              last;
    logic [CELL_W-1:0] row;
    logic [CELL_W-1:0] col;
    logic [WGT_W-1:0]  wgt;
    logic [DENS_W-1:0] wgt_ext;

    // window counters
    assign last = active_reg && (ci_reg == CNT_LAST) && (cj_reg == CNT_LAST);

    always_comb
    begin
        active_next = active_reg;
        ci_next     = ci_reg;
        cj_next     = cj_reg;
        if (cmd.start)
        begin
            active_next = 1'b1;
            ci_next     = '0;
            cj_next     = '0;
        end
        else if (active_reg)
        begin
            if (cj_reg == CNT_LAST)
            begin
                cj_next = '0;
                ci_next = ci_reg + 1'b1;
                if (ci_reg == CNT_LAST)
                    active_next = 1'b0;
            end
            else
            begin
                cj_next = cj_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            ci_reg       <= '0;
            cj_reg       <= '0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            ci_reg       <= ci_next;
            cj_reg       <= cj_next;
            s1_valid_reg <= active_reg;
            s1_last_reg  <= last;
        end
    end

    // read stage: cell address and its kernel weight
    assign row = by_reg + CELL_W'(ci_reg);
    assign col = bx_reg + CELL_W'(cj_reg);
    assign wgt = WGT_W'(tap_weight(ci_reg)) * WGT_W'(tap_weight(cj_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            sub_reg <= cmd.sub;
            bx_reg  <= cmd.base_x;
            by_reg  <= cmd.base_y;
        end
        s1_addr_reg <= {row, col};
        s1_wgt_reg  <= wgt;
    end

    // write stage: update the cell that came back
    assign wgt_ext = DENS_W'(s1_wgt_reg);

    always_comb
    begin
        req.rd_en   = active_reg;
        req.rd_addr = {row, col};
        req.wr_en   = s1_valid_reg;
        req.wr_addr = s1_addr_reg;
        req.wr_data = sub_reg ? (rd_data - wgt_ext) : (rd_data + wgt_ext);
    end

    assign done = s1_valid_reg && s1_last_reg;

endmodule

// ===== hw/rtl/tent_kernel_density_grid.sv =====
// ============================================================================
// tent_kernel_density_grid: density grid with tent kernel updates
// Queries read the squared density of a cell, adds and subtracts apply a
// separable tent kernel over a square window around a cell.
// ============================================================================
//
//  channel  direction  payload                    notes
//  item     in         kind, x_pos, y_pos         valid/ready
//  result   out        status, density_sq         valid/ready, one per item
//  cfg      in         cfg_wen, cfg_index, cfg_data  write only, no stall
//
//  a query steps through the map, check, magnitude and square states to
//  done; an add or subtract goes from check through the window walk, which
//  does one cell read-modify-write per cycle through the single grid memory.
//  a margin query, an off-grid update or an unused kind skips to done.
//  item.ready returns at the same edge at which the result is loaded.
//  after reset the grid memory is zeroed one cell a cycle, all of its cells,
//  with item.ready low; configuration writes are taken.
//  a new item transfers while a finished result still waits in the output
//  register; the sequencer stalls only when a second result is ready.
//
module tent_kernel_density_grid import tkd_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    tkd_item_if.sink             item,
    tkd_result_if.source         result,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic signed [GPOS_W-1:0] G_GRID   = GPOS_W'(GRID_CELLS);
    localparam logic signed [GPOS_W-1:0] G_WIN_LO = GPOS_W'(KERNEL_RADIUS);
    localparam logic signed [GPOS_W-1:0] G_WIN_HI = GPOS_W'(GRID_CELLS - KERNEL_RADIUS);

    tkd_state_t state_reg, state_next;

    logic [OFS_W-1:0]         view_offset_reg;
    logic [SCL_W-1:0]         view_scale_reg;
    logic [MARGIN_W-1:0]      edge_margin_reg;
    logic [DSQ_W-1:0]         far_density_reg;
    logic [ADDR_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [KIND_W-1:0]        kind_reg;
    logic signed [POS_W-1:0]  x_reg;
    logic signed [POS_W-1:0]  y_reg;
    logic signed [GPOS_W-1:0] gx;
    logic signed [GPOS_W-1:0] gy;
    logic [DENS_W-1:0]        mag_reg, mag_next;
    logic [STATUS_W-1:0]      res_status_reg, res_status_next;
    logic [DSQ_W-1:0]         res_dsq_reg, res_dsq_next;
    logic                     out_valid_reg;
    logic [STATUS_W-1:0]      out_status_reg;
    logic [DSQ_W-1:0]         out_dsq_reg;
    logic                     item_xfer;
    logic                     load_out;
    logic                     q_rd_en;
    logic [ADDR_W-1:0]        q_addr;
    logic [GPOS_W+CELL_W-1:0] q_lin;
    logic signed [GPOS_W-1:0] margin_s;
    logic                     in_margin;
    logic                     win_ok;
    logic signed [GPOS_W-1:0] bx_full;
    logic signed [GPOS_W-1:0] by_full;
    logic [2*DENS_W-1:0]      sq;
    logic                     clearing;
    tkd_walk_cmd_t            walk_cmd;
    tkd_ram_req_t             walk_req;
    logic                     walk_done;
    logic                     ram_wr_en;
    logic [ADDR_W-1:0]        ram_wr_addr;
    logic [DENS_W-1:0]        ram_wr_data;
    logic                     ram_rd_en;
    logic [ADDR_W-1:0]        ram_rd_addr;
    logic [DENS_W-1:0]        ram_rd_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_offset_reg <= VIEW_OFFSET_RST;
            view_scale_reg  <= VIEW_SCALE_RST;
            edge_margin_reg <= EDGE_MARGIN_RST;
            far_density_reg <= FAR_DENSITY_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_VIEW_OFFSET: view_offset_reg <= cfg_data[OFS_W-1:0];
                REG_VIEW_SCALE:  view_scale_reg  <= cfg_data[SCL_W-1:0];
                REG_EDGE_MARGIN: edge_margin_reg <= cfg_data[MARGIN_W-1:0];
                REG_FAR_DENSITY: far_density_reg <= cfg_data[DSQ_W-1:0];
            endcase
        end
    end

    // item capture
    assign item.ready = (state_reg == ST_IDLE);
    assign item_xfer  = item.valid && item.ready;

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            kind_reg <= item.kind;
            x_reg    <= item.x_pos;
            y_reg    <= item.y_pos;
        end
    end

    // grid coordinates
    tkd_map u_map_x (
        .clk    (clk),
        .pos    (x_reg),
        .offset (view_offset_reg),
        .scale  (view_scale_reg),
        .gpos   (gx)
    );

    tkd_map u_map_y (
        .clk    (clk),
        .pos    (y_reg),
        .offset (view_offset_reg),
        .scale  (view_scale_reg),
        .gpos   (gy)
    );

    // margin and window checks
    assign margin_s  = $signed({{(GPOS_W-MARGIN_W){1'b0}}, edge_margin_reg});
    assign in_margin = (gx < margin_s) || (gx > G_GRID - margin_s) || (gx >= G_GRID) ||
                       (gy < margin_s) || (gy > G_GRID - margin_s) || (gy >= G_GRID);
    assign win_ok    = (gx >= G_WIN_LO) && (gx < G_WIN_HI) &&
                       (gy >= G_WIN_LO) && (gy < G_WIN_HI);
    assign bx_full   = gx - G_WIN_LO;
    assign by_full   = gy - G_WIN_LO;

    // linear cell address of a query, row major
    assign q_lin  = {gy, {CELL_W{1'b0}}} + {{CELL_W{gx[GPOS_W-1]}}, gx};
    assign q_addr = q_lin[ADDR_W-1:0];

    assign sq = mag_reg * mag_reg;

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        mag_next        = mag_reg;
        res_status_next = res_status_reg;
        res_dsq_next    = res_dsq_reg;
        walk_cmd        = '0;
        q_rd_en         = 1'b0;
        load_out        = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (item_xfer)
                    state_next = ST_MAP_MUL;
            end
            ST_MAP_MUL:
                state_next = ST_MAP_TRUNC;
            ST_MAP_TRUNC:
                state_next = ST_CHECK;
            ST_CHECK:
            begin
                res_status_next = STATUS_DONE;
                res_dsq_next    = '0;
                state_next      = ST_DONE;
                unique case (kind_reg)
                    KIND_QUERY:
                    begin
                        if (in_margin)
                        begin
                            res_status_next = STATUS_MARGIN;
                            res_dsq_next    = far_density_reg;
                        end
                        else
                        begin
                            q_rd_en    = 1'b1;
                            state_next = ST_QUERY_MAG;
                        end
                    end
                    KIND_ADD, KIND_SUB:
                    begin
                        if (win_ok)
                        begin
                            walk_cmd.start  = 1'b1;
                            walk_cmd.sub    = (kind_reg == KIND_SUB);
                            walk_cmd.base_x = bx_full[CELL_W-1:0];
                            walk_cmd.base_y = by_full[CELL_W-1:0];
                            state_next      = ST_WALK;
                        end
                        else
                        begin
                            res_status_next = STATUS_OFF_GRID;
                        end
                    end
                    default:
                    begin
                        res_status_next = STATUS_DONE;
                    end
                endcase
            end
            ST_QUERY_MAG:
            begin
                mag_next   = ram_rd_data[DENS_W-1] ? (~ram_rd_data + 1'b1) : ram_rd_data;
                state_next = ST_QUERY_SQ;
            end
            ST_QUERY_SQ:
            begin
                res_dsq_next = sq[DSQ_W-1:0];
                state_next   = ST_DONE;
            end
            ST_WALK:
            begin
                if (walk_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg        <= mag_next;
        res_status_reg <= res_status_next;
        res_dsq_reg    <= res_dsq_next;
    end

    // window walker
    tkd_walk u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (walk_cmd),
        .rd_data (ram_rd_data),
        .req     (walk_req),
        .done    (walk_done)
    );

    // memory port selection
    assign clearing    = (state_reg == ST_CLEAR);
    assign ram_wr_en   = clearing || walk_req.wr_en;
    assign ram_wr_addr = clearing ? clr_cnt_reg : walk_req.wr_addr;
    assign ram_wr_data = clearing ? '0 : walk_req.wr_data;
    assign ram_rd_en   = q_rd_en || walk_req.rd_en;
    assign ram_rd_addr = q_rd_en ? q_addr : walk_req.rd_addr;

    tkd_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (DENS_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_dsq_reg    <= res_dsq_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.status     = out_status_reg;
    assign result.density_sq = out_dsq_reg;

`ifndef NO_ASSERTIONS
    // the walker touches the memory only during a window walk
    a_walk_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (walk_req.rd_en || walk_req.wr_en) |-> (state_reg == ST_WALK))
        else $error("walker memory access outside window walk");

    // a walk ends only while the sequencer waits for it
    a_done_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        walk_done |-> (state_reg == ST_WALK))
        else $error("walker done outside window walk");

    // a finished result reaches the output and frees the sequencer
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!out_valid_reg || result.ready))
        |=> (result.valid && state_reg == ST_IDLE))
        else $error("finished result not moved to output register");
`endif

endmodule

// ===== dv/tb.sv =====
// ============================================================================
// tb: testbench of the tent kernel density grid
// Drives query, add, subtract and unused-kind items under several view, margin
// and far density settings, keeps its own copy of the density grid to work out
// every result, and compares each result transfer field by field, in order.
// ============================================================================
module tb;
    import tkd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD = 10;
    localparam int NUM_PHASES  = 8;
    // a full window walk plus the map and check steps, twice over
    localparam int DRAIN_CYCLES = 2 * ((2 * KERNEL_RADIUS + 1) ** 2 + 6);
    // the grid clearing pass, then ~1360 items, each at most a full window walk
    // plus the map and check steps, and idling; the limit leaves ample room
    localparam int LIMIT_NS = 200_000_000;

    // the kind code that the block leaves unused
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [POS_W-1:0] x_pos;
        logic signed [POS_W-1:0] y_pos;
    } grid_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DSQ_W-1:0]    density_sq;
    } density_reply_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wen;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    tkd_item_if   item_if ();
    tkd_result_if result_if ();

    tent_kernel_density_grid dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_if),
        .result    (result_if),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // own copy of the grid and of the registers
    bit [DENS_W-1:0]   cell_copy [GRID_CELLS * GRID_CELLS];
    logic [OFS_W-1:0]    cur_offset = VIEW_OFFSET_RST;
    logic [SCL_W-1:0]    cur_scale  = VIEW_SCALE_RST;
    logic [MARGIN_W-1:0] cur_margin = EDGE_MARGIN_RST;
    logic [DSQ_W-1:0]    cur_far    = FAR_DENSITY_RST;

    grid_item_t     item_backlog [$];
    density_reply_t owed_replies [$];
    int             fail_count = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;

    // position to grid coordinate, product cut toward zero
    function automatic longint to_cell(input logic signed [POS_W-1:0] p);
        longint prod;
        prod = (longint'(p) + longint'(cur_offset)) * longint'(cur_scale);
        if (prod >= 0)
            return prod >>> MAP_SHIFT;
        return -((-prod) >>> MAP_SHIFT);
    endfunction

    function automatic bit window_fits(input longint g);
        return g - KERNEL_RADIUS >= 0 && g + KERNEL_RADIUS < GRID_CELLS;
    endfunction

    function automatic bit in_margin(input longint g);
        return g < longint'(cur_margin) || g > GRID_CELLS - longint'(cur_margin)
            || g >= GRID_CELLS;
    endfunction

    // apply one item to the grid copy and work out its result
    function automatic density_reply_t grid_step(input logic [KIND_W-1:0] kind,
                                                 input logic signed [POS_W-1:0] x,
                                                 input logic signed [POS_W-1:0] y);
        density_reply_t    reply;
        longint            gx;
        longint            gy;
        longint            idx;
        logic [DENS_W-1:0] dens;
        logic [DENS_W-1:0] neg_dens;
        logic [63:0]       mag;
        int                wgt;
        reply.status     = STATUS_DONE;
        reply.density_sq = '0;
        gx = to_cell(x);
        gy = to_cell(y);
        case (kind)
            KIND_QUERY:
            begin
                if (in_margin(gx) || in_margin(gy))
                begin
                    reply.status     = STATUS_MARGIN;
                    reply.density_sq = cur_far;
                end
                else
                begin
                    dens = cell_copy[gy * GRID_CELLS + gx];
                    // negative cells are squared as signed values
                    neg_dens = ~dens + 1'b1;
                    mag = dens[DENS_W-1] ? 64'(neg_dens) : 64'(dens);
                    reply.density_sq = DSQ_W'(mag * mag);
                end
            end
            KIND_ADD, KIND_SUB:
            begin
                if (window_fits(gx) && window_fits(gy))
                begin
                    for (int i = -KERNEL_RADIUS; i <= KERNEL_RADIUS; i++)
                    begin
                        for (int j = -KERNEL_RADIUS; j <= KERNEL_RADIUS; j++)
                        begin
                            wgt = (KERNEL_RADIUS - (i < 0 ? -i : i))
                                * (KERNEL_RADIUS - (j < 0 ? -j : j));
                            idx = (gy + i) * GRID_CELLS + (gx + j);
                            if (kind == KIND_SUB)
                                cell_copy[idx] = cell_copy[idx] - DENS_W'(wgt);
                            else
                                cell_copy[idx] = cell_copy[idx] + DENS_W'(wgt);
                        end
                    end
                end
                else
                    reply.status = STATUS_OFF_GRID;
            end
            default:
            begin
            end
        endcase
        return reply;
    endfunction

    // a position that lands on grid coordinate g under the current view
    function automatic logic signed [POS_W-1:0] pos_for_cell(input longint g);
        longint s;
        longint span;
        longint p;
        s = longint'(cur_scale);
        if (s == 0)
            return POS_W'($urandom);
        span = (longint'(1) <<< MAP_SHIFT) / s;
        if (span > 1024)
            span = 1024;
        p = ((g <<< MAP_SHIFT) + s - 1) / s - longint'(cur_offset);
        if (span > 1)
            p = p + longint'($urandom_range(0, int'(span - 1)));
        if (p < -(longint'(1) <<< (POS_W - 1)))
            p = -(longint'(1) <<< (POS_W - 1));
        if (p > (longint'(1) <<< (POS_W - 1)) - 1)
            p = (longint'(1) <<< (POS_W - 1)) - 1;
        return POS_W'(p);
    endfunction

    // mostly near the cluster, sometimes on a window or margin boundary, else anywhere on or near the grid
    function automatic longint pick_cell(input longint center);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return center + int'($urandom_range(0, 24)) - 12;
        if (r < 88)
        begin
            case ($urandom_range(0, 9))
                0: return KERNEL_RADIUS - 1;
                1: return KERNEL_RADIUS;
                2: return GRID_CELLS - 1 - KERNEL_RADIUS;
                3: return GRID_CELLS - KERNEL_RADIUS;
                4: return longint'(cur_margin) - 1;
                5: return longint'(cur_margin);
                6: return GRID_CELLS - longint'(cur_margin);
                7: return GRID_CELLS + 1 - longint'(cur_margin);
                8: return GRID_CELLS - 1;
                default: return GRID_CELLS;
            endcase
        end
        return longint'(int'($urandom_range(0, GRID_CELLS + 40))) - 20;
    endfunction

    task automatic push_item(input logic [KIND_W-1:0] kind,
                             input logic signed [POS_W-1:0] x,
                             input logic signed [POS_W-1:0] y);
        grid_item_t entry;
        entry.kind   = kind;
        entry.x_pos  = x;
        entry.y_pos  = y;
        item_backlog = {item_backlog, entry};
    endtask

    task automatic push_at(input logic [KIND_W-1:0] kind, input longint gx,
                           input longint gy);
        push_item(kind, pos_for_cell(gx), pos_for_cell(gy));
    endtask

    // updates around one cluster, queries, unused kinds and raw noise
    task automatic push_random(input int count, input bit sub_heavy,
                               input longint cx, input longint cy);
        int                r;
        logic [KIND_W-1:0] kind;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                push_item(KIND_W'($urandom_range(KIND_QUERY, KIND_UNUSED)),
                          POS_W'($urandom), POS_W'($urandom));
            else
            begin
                if (r < 15)
                    kind = KIND_UNUSED;
                else if (r < 55)
                    kind = KIND_QUERY;
                else if (r < 82)
                    kind = sub_heavy ? KIND_SUB : KIND_ADD;
                else
                    kind = sub_heavy ? KIND_ADD : KIND_SUB;
                push_at(kind, pick_cell(cx), pick_cell(cy));
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_VIEW_OFFSET: cur_offset = value[OFS_W-1:0];
            REG_VIEW_SCALE:  cur_scale  = value[SCL_W-1:0];
            REG_EDGE_MARGIN: cur_margin = value[MARGIN_W-1:0];
            default:         cur_far    = value[DSQ_W-1:0];
        endcase
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic program_grid(input longint ofs, input longint scl,
                                input longint margin, input logic [CFG_W-1:0] far);
        write_reg(REG_VIEW_OFFSET, CFG_W'(ofs));
        write_reg(REG_VIEW_SCALE, CFG_W'(scl));
        write_reg(REG_EDGE_MARGIN, CFG_W'(margin));
        write_reg(REG_FAR_DENSITY, far);
    endtask

    // wait until every item has gone in and every result has come out
    task automatic wait_drained();
        do
            @(negedge clk);
        while (item_backlog.size() != 0 || item_if.valid || owed_replies.size() != 0);
    endtask

    // item driver: predict on each transfer, then offer the next item
    always @(posedge clk or negedge rst_n)
    begin
        grid_item_t upcoming;
        if (!rst_n)
        begin
            item_if.valid <= 1'b0;
        end
        else
        begin
            if (item_if.valid && item_if.ready)
                owed_replies = {owed_replies, grid_step(item_if.kind, item_if.x_pos,
                                                        item_if.y_pos)};
            if (!item_if.valid || item_if.ready)
            begin
                if (item_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    upcoming = item_backlog[0];
                    item_backlog.delete(0);
                    item_if.valid <= 1'b1;
                    item_if.kind  <= upcoming.kind;
                    item_if.x_pos <= upcoming.x_pos;
                    item_if.y_pos <= upcoming.y_pos;
                end
                else
                    item_if.valid <= 1'b0;
            end
        end
    end

    // result monitor: compare each transfer with the oldest owed result
    always @(posedge clk or negedge rst_n)
    begin
        density_reply_t want;
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (owed_replies.size() == 0)
                begin
                    $error("result with no item outstanding: status %0d density_sq %0d",
                           result_if.status, result_if.density_sq);
                    fail_count++;
                end
                else
                begin
                    want = owed_replies[0];
                    owed_replies.delete(0);
                    if (result_if.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status,
                               result_if.status);
                        fail_count++;
                    end
                    if (result_if.density_sq !== want.density_sq)
                    begin
                        $error("density_sq: expected %0d, got %0d", want.density_sq,
                               result_if.density_sq);
                        fail_count++;
                    end
                end
            end
            result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // stimulus and phase control
    initial
    begin
        longint center_x;
        longint center_y;
        longint scl;
        longint ofs;
        rst_n           = 1'b0;
        cfg_wen         = 1'b0;
        cfg_index       = REG_VIEW_OFFSET;
        cfg_data        = '0;
        item_if.valid   = 1'b0;
        item_if.kind    = KIND_QUERY;
        item_if.x_pos   = '0;
        item_if.y_pos   = '0;
        result_if.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0:
                begin
                    // reset values stay in place
                end
                1: program_grid(0, (1 << SCL_W) - 1, 0, '0);
                2: program_grid((1 << OFS_W) - 1, 0, (1 << MARGIN_W) - 1, '1);
                3: program_grid(262144, 65536, (1 << MARGIN_W) - 1,
                                CFG_W'({$urandom, $urandom}));
                default:
                begin
                    // view roughly centered on the grid, random scale
                    scl = $urandom_range(8192, 131072);
                    ofs = (longint'(512) <<< MAP_SHIFT) / scl;
                    ofs = ofs - $urandom_range(0, int'(ofs / 4));
                    program_grid(ofs, scl, $urandom_range(0, 40),
                                 CFG_W'({$urandom, $urandom}));
                end
            endcase

            // pacing: none, sender idle, receiver stalls, both
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase

            if (ph == 0)
            begin
                // one tent, its peak, a side tap and the zero rim
                push_at(KIND_QUERY, 500, 500);
                push_at(KIND_ADD, 500, 500);
                push_at(KIND_QUERY, 500, 500);
                push_at(KIND_QUERY, 501, 500);
                push_at(KIND_QUERY, 510, 500);
                // drive the cells negative
                push_at(KIND_SUB, 500, 500);
                push_at(KIND_SUB, 500, 500);
                push_at(KIND_QUERY, 500, 500);
                push_at(KIND_QUERY, 495, 503);
                // window on and just past the lower and upper grid edges
                push_at(KIND_ADD, 10, 10);
                push_at(KIND_ADD, 9, 500);
                push_at(KIND_ADD, 1013, 1013);
                push_at(KIND_ADD, 500, 1014);
                push_at(KIND_SUB, 1014, 500);
                // margin boundaries and a coordinate past the grid
                push_at(KIND_QUERY, 9, 500);
                push_at(KIND_QUERY, 10, 10);
                push_at(KIND_QUERY, 1014, 1013);
                push_at(KIND_QUERY, 1015, 500);
                push_at(KIND_QUERY, 500, 1024);
                push_at(KIND_UNUSED, 500, 500);
                // raw position extremes
                push_item(KIND_QUERY, -21'sd1048576, 21'sd1048575);
                push_item(KIND_ADD, 21'sd1048575, -21'sd1048576);
                push_item(KIND_QUERY, 21'sd0, -21'sd1);
                push_item(KIND_SUB, -21'sd1, 21'sd0);
            end

            center_x = $urandom_range(KERNEL_RADIUS, GRID_CELLS - 1 - KERNEL_RADIUS);
            center_y = $urandom_range(KERNEL_RADIUS, GRID_CELLS - 1 - KERNEL_RADIUS);
            push_random((ph == 2) ? 40 : 185, (ph % 2) == 1, center_x, center_y);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // run limit
    initial
    begin
        #LIMIT_NS;
        $display("tb NOT OK");
        $finish;
    end

endmodule
